// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// The expression must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition");

`endif

// ===== rtl/tfs_pkg.sv =====
package tfs_pkg;

  typedef struct packed {
    logic               action;
    logic [15:0]        byte_address;
    logic [7:0]         byte_value;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
  } out_item_t;

  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_index_t;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [2:0] CH_GRAY = 3'd1;
  localparam logic [2:0] CH_RGB  = 3'd3;
  localparam logic [2:0] CH_RGBA = 3'd4;

  // ceil(2^30 / 255); exact quotient by 255 for dividends below 2^22.
  localparam logic [22:0] RECIP_255   = 23'd4210753;
  localparam int          RECIP_SHIFT = 30;
  localparam int          SCALE_SHIFT = 18;
  localparam int          LATENCY     = 9;
  localparam logic [15:0] LEVEL_MAX   = 16'd16384;

endpackage

// ===== rtl/tfs_ram.sv =====
module tfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/texture_four_texel_sampler.sv =====
// Four-texel wrapping texture sampler.
// Requests enter on in_item when start is high; busy is always low, so a
// request is taken every cycle. A request with action low writes
// byte_value into the texture store at byte_address and gives no result.
// A request with action high samples the texture at the fractional parts
// of u_coord and v_coord and gives one RGB result, Q2.14 per channel.
// Results appear on out_item with out_valid high for exactly one cycle.
// One result per cycle is sustained; the sample pipeline has nine
// register stages (capture, multipliers, wrap, row base, store read,
// weighting, sum, divide, output).
// The texture store is twelve replicated byte RAMs, one per texel and
// channel, all written together, so all twelve reads issue in one cycle.
// Requests keep their order: loads write at the stage where samples read.
// Registers are written on cfg_index/cfg_data when cfg_valid is high;
// cfg_ready is always high. Writes must happen only while no sample is
// in flight; it is not enforced. Reset clears pipeline valid bits and
// the registers (width 0, height 0, three channels); store contents are
// undefined until loaded. The receiver cannot stall; out_valid is a strobe.
`include "assert_macros.svh"

module texture_four_texel_sampler #(
  parameter int TEXTURE_BYTES = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tfs_pkg::in_item_t   in_item,
  output logic                out_valid,
  output tfs_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [10:0]         cfg_data
);

  localparam int AW = $clog2(TEXTURE_BYTES);

  logic [10:0] tex_width_r;
  logic [10:0] tex_height_r;
  logic [2:0]  tex_channels_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r    <= '0;
      tex_height_r   <= '0;
      tex_channels_r <= tfs_pkg::CH_RGB;
    end else if (cfg_valid) begin
      unique case (tfs_pkg::cfg_index_t'(cfg_index))
        tfs_pkg::CFG_WIDTH:    tex_width_r    <= cfg_data;
        tfs_pkg::CFG_HEIGHT:   tex_height_r   <= cfg_data;
        tfs_pkg::CFG_CHANNELS: tex_channels_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Stage A: request capture.
  logic              a_vld_r;
  tfs_pkg::in_item_t a_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
    a_item_r <= in_item;
  end

  // Stage B: coordinate and weight products.
  logic        b_smp_r, b_ld_r;
  logic [15:0] b_addr_r;
  logic [7:0]  b_val_r;
  logic [26:0] b_iprod_r, b_jprod_r;
  logic [21:0] b_area_r;
  logic [32:0] b_wt_r [4];
  logic [15:0] a_fu, a_fv;
  logic [16:0] a_nfu, a_nfv;

  assign a_fu  = a_item_r.u_coord[15:0];
  assign a_fv  = a_item_r.v_coord[15:0];
  assign a_nfu = 17'h10000 - {1'b0, a_fu};
  assign a_nfv = 17'h10000 - {1'b0, a_fv};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_smp_r <= 1'b0;
      b_ld_r  <= 1'b0;
    end else begin
      b_smp_r <= a_vld_r && a_item_r.action == tfs_pkg::ACT_SAMPLE;
      b_ld_r  <= a_vld_r && a_item_r.action == tfs_pkg::ACT_LOAD;
    end
    b_addr_r  <= a_item_r.byte_address;
    b_val_r   <= a_item_r.byte_value;
    b_iprod_r <= 27'(a_fu) * 27'(tex_width_r);
    b_jprod_r <= 27'(a_fv) * 27'(tex_height_r);
    b_area_r  <= 22'(tex_width_r) * 22'(tex_height_r);
    b_wt_r[0] <= 33'(a_nfu) * 33'(a_nfv);
    b_wt_r[1] <= 33'(a_fu) * 33'(a_nfv);
    b_wt_r[2] <= 33'(a_nfu) * 33'(a_fv);
    b_wt_r[3] <= 33'(a_fu) * 33'(a_fv);
  end

  // Stage C: clamp, wrap and texture validity.
  logic        c_smp_r, c_ld_r, c_ok_r;
  logic [15:0] c_addr_r;
  logic [7:0]  c_val_r;
  logic [10:0] c_i_r, c_i1_r, c_j_r, c_j1_r;
  logic [32:0] c_wt_r [4];
  logic [10:0] b_i, b_i1, b_j, b_j1;
  logic        b_ok;

  always_comb begin
    logic [10:0] iraw, jraw;
    logic [24:0] bytes;
    iraw  = b_iprod_r[26:16];
    jraw  = b_jprod_r[26:16];
    b_i   = (iraw >= tex_width_r)  ? tex_width_r  - 11'd1 : iraw;
    b_j   = (jraw >= tex_height_r) ? tex_height_r - 11'd1 : jraw;
    b_i1  = (b_i + 11'd1 >= tex_width_r)  ? '0 : b_i + 11'd1;
    b_j1  = (b_j + 11'd1 >= tex_height_r) ? '0 : b_j + 11'd1;
    bytes = 25'(b_area_r) * 25'(tex_channels_r);
    b_ok  = tex_width_r != '0 && tex_height_r != '0 &&
            (tex_channels_r == tfs_pkg::CH_GRAY || tex_channels_r == tfs_pkg::CH_RGB ||
             tex_channels_r == tfs_pkg::CH_RGBA) &&
            32'(bytes) <= TEXTURE_BYTES;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_smp_r <= 1'b0;
      c_ld_r  <= 1'b0;
    end else begin
      c_smp_r <= b_smp_r;
      c_ld_r  <= b_ld_r;
    end
    c_ok_r   <= b_ok;
    c_addr_r <= b_addr_r;
    c_val_r  <= b_val_r;
    c_i_r    <= b_i;
    c_i1_r   <= b_i1;
    c_j_r    <= b_j;
    c_j1_r   <= b_j1;
    c_wt_r   <= b_wt_r;
  end

  // Stage D: row bases.
  logic        d_smp_r, d_ld_r, d_ok_r;
  logic [15:0] d_addr_r;
  logic [7:0]  d_val_r;
  logic [10:0] d_i_r, d_i1_r;
  logic [21:0] d_row_r, d_row1_r;
  logic [32:0] d_wt_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_smp_r <= 1'b0;
      d_ld_r  <= 1'b0;
    end else begin
      d_smp_r <= c_smp_r;
      d_ld_r  <= c_ld_r;
    end
    d_ok_r   <= c_ok_r;
    d_addr_r <= c_addr_r;
    d_val_r  <= c_val_r;
    d_i_r    <= c_i_r;
    d_i1_r   <= c_i1_r;
    d_row_r  <= 22'(c_j_r) * 22'(tex_width_r);
    d_row1_r <= 22'(c_j1_r) * 22'(tex_width_r);
    d_wt_r   <= c_wt_r;
  end

  // Stage E: texel addresses, store access; loads write here too.
  logic [AW-1:0] d_rd_addr [12];
  logic          d_wr_en;
  logic [7:0]    e_byte [12];

  always_comb begin
    logic [22:0] idx [4];
    logic [25:0] base;
    idx[0] = 23'(d_row_r)  + 23'(d_i_r);
    idx[1] = 23'(d_row_r)  + 23'(d_i1_r);
    idx[2] = 23'(d_row1_r) + 23'(d_i_r);
    idx[3] = 23'(d_row1_r) + 23'(d_i1_r);
    for (int k = 0; k < 4; k++) begin
      unique case (tex_channels_r)
        tfs_pkg::CH_RGB:  base = 26'(idx[k]) + {2'b0, idx[k], 1'b0};
        tfs_pkg::CH_RGBA: base = {1'b0, idx[k], 2'b0};
        default:          base = 26'(idx[k]);
      endcase
      for (int c = 0; c < 3; c++) begin
        if (tex_channels_r == tfs_pkg::CH_GRAY) begin
          d_rd_addr[k*3+c] = AW'(base);
        end else begin
          d_rd_addr[k*3+c] = AW'(base + 26'(c));
        end
      end
    end
  end

  assign d_wr_en = d_ld_r && 32'(d_addr_r) < TEXTURE_BYTES;

  for (genvar g = 0; g < 12; g++) begin : g_store
    tfs_ram #(
      .WIDTH (8),
      .DEPTH (TEXTURE_BYTES)
    ) u_ram (
      .clk     (clk),
      .wr_en   (d_wr_en),
      .wr_addr (AW'(d_addr_r)),
      .wr_data (d_val_r),
      .rd_addr (d_rd_addr[g]),
      .rd_data (e_byte[g])
    );
  end

  logic        e_smp_r, e_ok_r;
  logic [32:0] e_wt_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_smp_r <= 1'b0;
    end else begin
      e_smp_r <= d_smp_r;
    end
    e_ok_r <= d_ok_r;
    e_wt_r <= d_wt_r;
  end

  // Stage F: weighted texel channels.
  logic        f_smp_r, f_ok_r;
  logic [40:0] f_prod_r [12];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_smp_r <= 1'b0;
    end else begin
      f_smp_r <= e_smp_r;
    end
    f_ok_r <= e_ok_r;
    for (int g = 0; g < 12; g++) begin
      f_prod_r[g] <= 41'(e_wt_r[g/3]) * 41'(e_byte[g]);
    end
  end

  // Stage G: channel sums.
  logic        g_smp_r, g_ok_r;
  logic [42:0] g_sum_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_smp_r <= 1'b0;
    end else begin
      g_smp_r <= f_smp_r;
    end
    g_ok_r <= f_ok_r;
    for (int c = 0; c < 3; c++) begin
      g_sum_r[c] <= 43'(f_prod_r[c]) + 43'(f_prod_r[3+c]) +
                    43'(f_prod_r[6+c]) + 43'(f_prod_r[9+c]);
    end
  end

  // Stage H: divide by 255 through the reciprocal.
  logic        h_smp_r, h_ok_r;
  logic [44:0] h_q_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_smp_r <= 1'b0;
    end else begin
      h_smp_r <= g_smp_r;
    end
    h_ok_r <= g_ok_r;
    for (int c = 0; c < 3; c++) begin
      h_q_r[c] <= 45'(g_sum_r[c][tfs_pkg::SCALE_SHIFT +: 22]) * 45'(tfs_pkg::RECIP_255);
    end
  end

  // Output register.
  logic               out_valid_r;
  tfs_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= h_smp_r;
    end
    if (h_ok_r) begin
      out_item_r.red_level   <= 16'(h_q_r[0] >> tfs_pkg::RECIP_SHIFT);
      out_item_r.green_level <= 16'(h_q_r[1] >> tfs_pkg::RECIP_SHIFT);
      out_item_r.blue_level  <= 16'(h_q_r[2] >> tfs_pkg::RECIP_SHIFT);
    end else begin
      out_item_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_IMPLIES(a_result_follows_sample, clk, rst_n, out_valid,
    $past(start && in_item.action == tfs_pkg::ACT_SAMPLE, tfs_pkg::LATENCY))
  `ASSERT_IMPLIES(a_level_range, clk, rst_n, out_valid,
    out_item.red_level <= tfs_pkg::LEVEL_MAX && out_item.green_level <= tfs_pkg::LEVEL_MAX &&
    out_item.blue_level <= tfs_pkg::LEVEL_MAX)
  `ASSERT_NEVER(a_load_and_sample_same_stage, clk, rst_n, d_smp_r && d_ld_r)

endmodule
